>>> rtl/pcrm_pkg.sv
// pulse counter rate meter: shared types, widths, codes and reset values
// no dependencies; used by every module of the block
`default_nettype none

package pcrm_pkg;

  localparam int COUNT_W  = 32;
  localparam int FIELD_W  = 32;
  localparam int VALUE_W  = 48;
  localparam int MULT_W   = 32;
  localparam int TPS_W    = 16;
  localparam int PROD_W   = 2 * MULT_W;
  localparam int AHI_W    = COUNT_W + TPS_W - MULT_W;
  localparam int DVD_W    = COUNT_W + TPS_W + MULT_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [1:0] EDGE_RISE = 2'd0;
  localparam logic [1:0] EDGE_FALL = 2'd1;
  localparam logic [1:0] EDGE_BOTH = 2'd2;

  localparam logic [1:0] REG_EDGE_MODE  = 2'd0;
  localparam logic [1:0] REG_SHOW_SPEED = 2'd1;
  localparam logic [1:0] REG_MULTIPLIER = 2'd2;
  localparam logic [1:0] REG_TPS        = 2'd3;

  localparam logic [MULT_W-1:0] MULT_RESET = 32'd65536;
  localparam logic [TPS_W-1:0]  TPS_RESET  = 16'd1000;

  typedef struct packed {
    logic [1:0]        edge_mode;
    logic              show_speed;
    logic [MULT_W-1:0] multiplier;
    logic [TPS_W-1:0]  ticks_per_second;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] edges;
    logic [COUNT_W-1:0] ticks;
  } snap_t;

endpackage

`default_nettype wire

>>> rtl/pulse_counter_rate_meter.sv
// pulse counter rate meter: one sample beat per cycle while the snapshot queue is not full;
// a read beat yields one result; the back end computes reads one at a time, in raw mode
// through the multiplier and in speed mode also through the 80-step bit-serial divider;
// two pending reads queue before full, and while full no beats are accepted
// synchronous active-high reset clears counters, queues and restores config
`default_nettype none

module pulse_counter_rate_meter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          pin_level,
  input  wire logic                          time_tick,
  input  wire logic                          read_request,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [pcrm_pkg::VALUE_W-1:0]       value,
  output logic [pcrm_pkg::FIELD_W-1:0]       edges_seen,
  output logic [pcrm_pkg::FIELD_W-1:0]       elapsed_ticks,
  output logic                               no_time,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  pcrm_pkg::cfg_t  cfg;
  pcrm_pkg::snap_t front_snap;
  pcrm_pkg::snap_t queue_snap;
  logic            snap_push;
  logic            snap_valid;
  logic            snap_pop;
  logic            out_valid;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_mode        <= pcrm_pkg::EDGE_RISE;
      cfg.show_speed       <= 1'b0;
      cfg.multiplier       <= pcrm_pkg::MULT_RESET;
      cfg.ticks_per_second <= pcrm_pkg::TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcrm_pkg::REG_EDGE_MODE:  cfg.edge_mode        <= cfg_data[1:0];
        pcrm_pkg::REG_SHOW_SPEED: cfg.show_speed       <= cfg_data[0];
        pcrm_pkg::REG_MULTIPLIER: cfg.multiplier       <= cfg_data[pcrm_pkg::MULT_W-1:0];
        pcrm_pkg::REG_TPS:        cfg.ticks_per_second <= cfg_data[pcrm_pkg::TPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pcrm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pin_level    (pin_level),
    .time_tick    (time_tick),
    .read_request (read_request),
    .edge_mode    (cfg.edge_mode),
    .snap_push    (snap_push),
    .snap_data    (front_snap)
  );

  pcrm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (snap_push),
    .wdata (front_snap),
    .full  (full),
    .valid (snap_valid),
    .pop   (snap_pop),
    .rdata (queue_snap)
  );

  pcrm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .snap_valid    (snap_valid),
    .snap_data     (queue_snap),
    .snap_pop      (snap_pop),
    .out_valid     (out_valid),
    .out_pop       (pop),
    .value         (value),
    .edges_seen    (edges_seen),
    .elapsed_ticks (elapsed_ticks),
    .no_time       (no_time)
  );

endmodule

`default_nettype wire

>>> rtl/pcrm_front.sv
// pulse counter rate meter front: edge detection, edge and tick counters
// takes a snapshot of both counts on a read; depends on pcrm_pkg
`default_nettype none

module pcrm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic          pin_level,
  input  wire logic          time_tick,
  input  wire logic          read_request,
  input  wire logic [1:0]    edge_mode,
  output logic               snap_push,
  output pcrm_pkg::snap_t    snap_data
);

  logic                         previous_level;
  logic [pcrm_pkg::COUNT_W-1:0] edge_count;
  logic [pcrm_pkg::COUNT_W-1:0] tick_count;
  logic [pcrm_pkg::COUNT_W-1:0] edge_count_next;
  logic [pcrm_pkg::COUNT_W-1:0] tick_count_next;
  logic                         rise;
  logic                         fall;
  logic                         counted;

  always_comb begin
    rise = !previous_level && pin_level;
    fall = previous_level && !pin_level;
    unique case (edge_mode)
      pcrm_pkg::EDGE_RISE: counted = rise;
      pcrm_pkg::EDGE_FALL: counted = fall;
      default:             counted = rise || fall;
    endcase
    edge_count_next = edge_count;
    if (counted && edge_count != pcrm_pkg::COUNT_MAX) begin
      edge_count_next = edge_count + 1'b1;
    end
    tick_count_next = tick_count;
    if (time_tick && tick_count != pcrm_pkg::COUNT_MAX) begin
      tick_count_next = tick_count + 1'b1;
    end
  end

  assign snap_push       = accept && read_request;
  assign snap_data.edges = edge_count_next;
  assign snap_data.ticks = tick_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      edge_count     <= '0;
      tick_count     <= '0;
    end else if (accept) begin
      previous_level <= pin_level;
      if (read_request) begin
        edge_count <= '0;
        tick_count <= '0;
      end else begin
        edge_count <= edge_count_next;
        tick_count <= tick_count_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcrm_queue.sv
// pulse counter rate meter: two-entry snapshot queue between front and back
// depends on pcrm_pkg
`default_nettype none

module pcrm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  pcrm_pkg::snap_t      wdata,
  output logic                 full,
  output logic                 valid,
  input  wire logic            pop,
  output pcrm_pkg::snap_t      rdata
);

  pcrm_pkg::snap_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign full    = count[1];
  assign valid   = count != 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcrm_back.sv
// pulse counter rate meter back: shared 32x32 multiplier, bit-serial divider,
// saturation and the result register; depends on pcrm_pkg
`default_nettype none

module pcrm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  pcrm_pkg::cfg_t                     cfg,
  input  wire logic                          snap_valid,
  input  pcrm_pkg::snap_t                    snap_data,
  output logic                               snap_pop,
  output logic                               out_valid,
  input  wire logic                          out_pop,
  output logic [pcrm_pkg::VALUE_W-1:0]       value,
  output logic [pcrm_pkg::FIELD_W-1:0]       edges_seen,
  output logic [pcrm_pkg::FIELD_W-1:0]       elapsed_ticks,
  output logic                               no_time
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_M1   = 9'b000000010,
    S_M2   = 9'b000000100,
    S_M3   = 9'b000001000,
    S_SUM  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_QUO  = 9'b001000000,
    S_SAT  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t                           state;
  pcrm_pkg::snap_t                  snap;
  logic [pcrm_pkg::PROD_W-1:0]      prod;
  logic [pcrm_pkg::AHI_W-1:0]       ahi;
  logic [pcrm_pkg::PROD_W-1:0]      lo_part;
  logic [pcrm_pkg::DVD_W-1:0]       dvd;
  logic [pcrm_pkg::COUNT_W-1:0]     rem;
  logic [pcrm_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic [pcrm_pkg::VALUE_W-1:0]     res_value;
  logic                             res_no_time;

  logic [pcrm_pkg::MULT_W-1:0]      mul_a;
  logic [pcrm_pkg::MULT_W-1:0]      mul_b;
  logic [pcrm_pkg::PROD_W-1:0]      mul_p;
  logic [pcrm_pkg::COUNT_W:0]       rem_shift;
  logic [pcrm_pkg::COUNT_W:0]       rem_sub;
  logic                             rem_ge;
  logic                             out_free;

  always_comb begin
    unique case (state)
      S_M1: begin
        mul_a = snap.edges;
        mul_b = cfg.show_speed ? pcrm_pkg::MULT_W'(cfg.ticks_per_second) : cfg.multiplier;
      end
      S_M2: begin
        mul_a = prod[pcrm_pkg::MULT_W-1:0];
        mul_b = cfg.multiplier;
      end
      S_M3: begin
        mul_a = pcrm_pkg::MULT_W'(ahi);
        mul_b = cfg.multiplier;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p     = pcrm_pkg::PROD_W'(mul_a) * pcrm_pkg::PROD_W'(mul_b);
    rem_shift = {rem, dvd[pcrm_pkg::DVD_W-1]};
    rem_sub   = rem_shift - {1'b0, snap.ticks};
    rem_ge    = rem_shift >= {1'b0, snap.ticks};
  end

  assign snap_pop = (state == S_IDLE) && snap_valid;
  assign out_free = !out_valid || out_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (snap_valid) begin
            if (cfg.show_speed && snap_data.ticks == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_M1;
            end
          end
        end
        S_M1:  state <= cfg.show_speed ? S_M2 : S_SAT;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_SUM;
        S_SUM: state <= S_DIV;
        S_DIV: begin
          if (div_cnt == pcrm_pkg::DIV_CNT_W'(pcrm_pkg::DIV_STEPS - 1)) begin
            state <= S_QUO;
          end
        end
        S_QUO: state <= S_OUT;
        S_SAT: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        snap        <= snap_data;
        res_value   <= '0;
        res_no_time <= cfg.show_speed;
      end
      S_M1: prod <= mul_p;
      S_M2: begin
        ahi  <= prod[pcrm_pkg::COUNT_W+pcrm_pkg::TPS_W-1:pcrm_pkg::MULT_W];
        prod <= mul_p;
      end
      S_M3: begin
        lo_part <= prod;
        prod    <= mul_p;
      end
      S_SUM: begin
        dvd     <= pcrm_pkg::DVD_W'(lo_part)
                 + {prod[pcrm_pkg::DVD_W-pcrm_pkg::MULT_W-1:0], {pcrm_pkg::MULT_W{1'b0}}};
        rem     <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        rem     <= rem_ge ? rem_sub[pcrm_pkg::COUNT_W-1:0] : rem_shift[pcrm_pkg::COUNT_W-1:0];
        dvd     <= {dvd[pcrm_pkg::DVD_W-2:0], rem_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      S_QUO: begin
        res_no_time <= 1'b0;
        res_value   <= (|dvd[pcrm_pkg::DVD_W-1:pcrm_pkg::VALUE_W]) ? pcrm_pkg::VALUE_MAX
                       : dvd[pcrm_pkg::VALUE_W-1:0];
      end
      S_SAT: begin
        res_no_time <= 1'b0;
        res_value   <= (|prod[pcrm_pkg::PROD_W-1:pcrm_pkg::VALUE_W]) ? pcrm_pkg::VALUE_MAX
                       : prod[pcrm_pkg::VALUE_W-1:0];
      end
      S_OUT: begin
        if (out_free) begin
          value         <= res_value;
          edges_seen    <= snap.edges;
          elapsed_ticks <= snap.ticks;
          no_time       <= res_no_time;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt < pcrm_pkg::DIV_CNT_W'(pcrm_pkg::DIV_STEPS)))
    else $error("divider step count out of range");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && snap.ticks != '0) |-> (rem < snap.ticks))
    else $error("divider remainder not below divisor");

  a_snap_starts_work: assert property (@(posedge clk) disable iff (rst)
    snap_pop |=> (state != S_IDLE))
    else $error("snapshot taken but sequencer stayed idle");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_pop) |=> (out_valid && $stable(value) && $stable(no_time)))
    else $error("waiting result changed before pop");
`endif

endmodule

`default_nettype wire
